// File: design/ard_pkg.sv
// ----------------------------------------------------------------------------
// ard_pkg
// Shared types, field codes and the Pearson permutation table for the
// archive record deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ard_pkg;

   // record framing
   localparam logic [7:0] MAGIC_BYTE = 8'h42;

   // header position codes
   localparam logic [3:0] POS_MAGIC     = 4'd0;
   localparam logic [3:0] POS_MODE_LAST = 4'd3;
   localparam logic [3:0] POS_NAME_LAST = 4'd5;
   localparam logic [3:0] POS_BODY      = 4'd12;

   // byte class codes
   localparam logic [2:0] CLS_MAGIC    = 3'd0;
   localparam logic [2:0] CLS_MODE     = 3'd1;
   localparam logic [2:0] CLS_NAME_LEN = 3'd2;
   localparam logic [2:0] CLS_BODY_LEN = 3'd3;
   localparam logic [2:0] CLS_NAME     = 3'd4;
   localparam logic [2:0] CLS_CONTENT  = 3'd5;
   localparam logic [2:0] CLS_HASH     = 3'd6;
   localparam logic [2:0] CLS_ERROR    = 3'd7;

   // one result beat
   typedef struct packed {
      logic [2:0]  byte_class;
      logic [7:0]  data_byte;
      logic        record_done;
      logic [23:0] record_mode;
      logic [15:0] name_length;
      logic [47:0] body_length;
      logic        hash_ok;
      logic        magic_error;
   } result_type;

   // pearson permutation
   localparam logic [7:0] PEARSON_ROM [0:255] = '{
      8'd241, 8'd18,  8'd181, 8'd164, 8'd92,  8'd237, 8'd100, 8'd216,
      8'd183, 8'd107, 8'd2,   8'd12,  8'd43,  8'd246, 8'd90,  8'd143,
      8'd251, 8'd49,  8'd228, 8'd134, 8'd215, 8'd20,  8'd193, 8'd172,
      8'd140, 8'd227, 8'd148, 8'd118, 8'd57,  8'd72,  8'd119, 8'd174,
      8'd78,  8'd14,  8'd97,  8'd3,   8'd208, 8'd252, 8'd11,  8'd195,
      8'd31,  8'd28,  8'd121, 8'd206, 8'd149, 8'd23,  8'd83,  8'd154,
      8'd223, 8'd109, 8'd89,  8'd10,  8'd178, 8'd243, 8'd42,  8'd194,
      8'd221, 8'd131, 8'd212, 8'd94,  8'd205, 8'd240, 8'd161, 8'd7,
      8'd62,  8'd214, 8'd222, 8'd219, 8'd1,   8'd84,  8'd95,  8'd58,
      8'd103, 8'd60,  8'd33,  8'd111, 8'd188, 8'd218, 8'd186, 8'd166,
      8'd146, 8'd189, 8'd201, 8'd155, 8'd68,  8'd145, 8'd44,  8'd163,
      8'd69,  8'd196, 8'd115, 8'd231, 8'd61,  8'd157, 8'd165, 8'd213,
      8'd139, 8'd112, 8'd173, 8'd191, 8'd142, 8'd88,  8'd106, 8'd250,
      8'd8,   8'd127, 8'd26,  8'd126, 8'd0,   8'd96,  8'd52,  8'd182,
      8'd113, 8'd38,  8'd242, 8'd48,  8'd204, 8'd160, 8'd15,  8'd54,
      8'd158, 8'd192, 8'd81,  8'd125, 8'd245, 8'd239, 8'd101, 8'd17,
      8'd136, 8'd110, 8'd24,  8'd53,  8'd132, 8'd117, 8'd102, 8'd153,
      8'd226, 8'd4,   8'd203, 8'd199, 8'd16,  8'd249, 8'd211, 8'd167,
      8'd55,  8'd255, 8'd254, 8'd116, 8'd122, 8'd13,  8'd236, 8'd93,
      8'd144, 8'd86,  8'd59,  8'd76,  8'd150, 8'd162, 8'd207, 8'd77,
      8'd176, 8'd32,  8'd124, 8'd171, 8'd29,  8'd45,  8'd30,  8'd67,
      8'd184, 8'd51,  8'd22,  8'd105, 8'd170, 8'd253, 8'd180, 8'd187,
      8'd130, 8'd156, 8'd98,  8'd159, 8'd220, 8'd40,  8'd133, 8'd135,
      8'd114, 8'd147, 8'd75,  8'd73,  8'd210, 8'd21,  8'd129, 8'd39,
      8'd138, 8'd91,  8'd41,  8'd235, 8'd47,  8'd185, 8'd9,   8'd82,
      8'd64,  8'd87,  8'd244, 8'd50,  8'd74,  8'd233, 8'd175, 8'd247,
      8'd120, 8'd6,   8'd169, 8'd85,  8'd66,  8'd104, 8'd80,  8'd71,
      8'd230, 8'd152, 8'd225, 8'd34,  8'd248, 8'd198, 8'd63,  8'd168,
      8'd179, 8'd141, 8'd137, 8'd5,   8'd19,  8'd79,  8'd232, 8'd128,
      8'd202, 8'd46,  8'd70,  8'd37,  8'd209, 8'd217, 8'd123, 8'd27,
      8'd177, 8'd25,  8'd56,  8'd65,  8'd229, 8'd36,  8'd197, 8'd234,
      8'd108, 8'd35,  8'd151, 8'd238, 8'd200, 8'd224, 8'd99,  8'd190
   };

endpackage

`default_nettype wire

// File: design/ard_parse.sv
// ----------------------------------------------------------------------------
// ard_parse
// Record parser state and per-byte decode: header assembly, body counting,
// Pearson hash folding and sticky magic error. State advances on fire.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ard_parse (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire logic [7:0]          data_byte,
   output ard_pkg::result_type      result
);

   logic [3:0]  position_ff,   position_in;
   logic [48:0] count_ff,      count_in;
   logic [23:0] mode_ff,       mode_in;
   logic [15:0] name_len_ff,   name_len_in;
   logic [47:0] body_len_ff,   body_len_in;
   logic [7:0]  hash_ff,       hash_in;
   logic        error_ff,      error_in;

   logic [7:0]  folded_hash;
   logic [48:0] total_len;
   logic [48:0] count_inc;
   logic [2:0]  byte_class;
   logic        closing;
   logic        hash_match;

   // hash step and body bookkeeping
   assign folded_hash = ard_pkg::PEARSON_ROM[hash_ff ^ data_byte];
   assign total_len   = {33'd0, name_len_ff} + {1'b0, body_len_ff};
   assign count_inc   = count_ff + 49'd1;
   assign hash_match  = (data_byte == hash_ff);

   // per-byte decode
   always_comb begin
      position_in = position_ff;
      count_in    = count_ff;
      mode_in     = mode_ff;
      name_len_in = name_len_ff;
      body_len_in = body_len_ff;
      hash_in     = hash_ff;
      error_in    = error_ff;
      byte_class  = ard_pkg::CLS_ERROR;
      closing     = 1'b0;

      if (position_ff == ard_pkg::POS_MAGIC) begin
         if (data_byte == ard_pkg::MAGIC_BYTE) begin
            byte_class  = ard_pkg::CLS_MAGIC;
            hash_in     = folded_hash;
            position_in = position_ff + 4'd1;
         end else begin
            byte_class = ard_pkg::CLS_ERROR;
            error_in   = 1'b1;
         end
      end else if (position_ff <= ard_pkg::POS_MODE_LAST) begin
         byte_class  = ard_pkg::CLS_MODE;
         mode_in     = {mode_ff[15:0], data_byte};
         hash_in     = folded_hash;
         position_in = position_ff + 4'd1;
      end else if (position_ff <= ard_pkg::POS_NAME_LAST) begin
         byte_class  = ard_pkg::CLS_NAME_LEN;
         name_len_in = {name_len_ff[7:0], data_byte};
         hash_in     = folded_hash;
         position_in = position_ff + 4'd1;
      end else if (position_ff < ard_pkg::POS_BODY) begin
         byte_class  = ard_pkg::CLS_BODY_LEN;
         body_len_in = {body_len_ff[39:0], data_byte};
         hash_in     = folded_hash;
         position_in = position_ff + 4'd1;
      end else if (count_ff < {33'd0, name_len_ff}) begin
         byte_class = ard_pkg::CLS_NAME;
         hash_in    = folded_hash;
         count_in   = count_inc;
      end else if (count_ff < total_len) begin
         byte_class = ard_pkg::CLS_CONTENT;
         hash_in    = folded_hash;
         count_in   = count_inc;
      end else begin
         byte_class = ard_pkg::CLS_HASH;
         closing    = 1'b1;
      end
   end

   // result beat reports the assembled fields before the record clears
   always_comb begin
      result.byte_class  = byte_class;
      result.data_byte   = data_byte;
      result.record_done = closing;
      result.record_mode = mode_in;
      result.name_length = name_len_in;
      result.body_length = body_len_in;
      result.hash_ok     = closing & hash_match;
      result.magic_error = error_in;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= ard_pkg::POS_MAGIC;
         count_ff    <= '0;
         mode_ff     <= '0;
         name_len_ff <= '0;
         body_len_ff <= '0;
         hash_ff     <= '0;
         error_ff    <= 1'b0;
      end else if (fire) begin
         error_ff <= error_in;
         if (closing) begin
            position_ff <= ard_pkg::POS_MAGIC;
            count_ff    <= '0;
            mode_ff     <= '0;
            name_len_ff <= '0;
            body_len_ff <= '0;
            hash_ff     <= '0;
         end else begin
            position_ff <= position_in;
            count_ff    <= count_in;
            mode_ff     <= mode_in;
            name_len_ff <= name_len_in;
            body_len_ff <= body_len_in;
            hash_ff     <= hash_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: design/archive_record_deframer_top.sv
// A byte accepted into the input register is parsed into the result register.
// Throughput: one byte per cycle while the result side does not stall; the hash
// table lookup and header and body count update are combinational between them.
// Reset: synchronous, clears the parser state, the hash, the sticky error and
// both stage valids; no result is pending after reset.
// ----------------------------------------------------------------------------
// archive_record_deframer_top
// Byte-stream archive record parser: input register, parse logic, result
// register with valid/stall handshakes on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module archive_record_deframer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_stream_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [2:0]  rsp_byte_class,
   output      logic [7:0]  rsp_data_byte,
   output      logic        rsp_record_done,
   output      logic [23:0] rsp_record_mode,
   output      logic [15:0] rsp_name_length,
   output      logic [47:0] rsp_body_length,
   output      logic        rsp_hash_ok,
   output      logic        rsp_magic_error
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   ard_pkg::result_type  out_ff;
   ard_pkg::result_type  parse_result;
   logic                 out_open;
   logic                 fire;

   // stage handshakes
   assign out_open  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   // parser
   ard_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (in_byte_ff),
      .result    (parse_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_open) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= parse_result;
      end
   end

   // result beat ports
   assign rsp_valid       = out_valid_ff;
   assign rsp_byte_class  = out_ff.byte_class;
   assign rsp_data_byte   = out_ff.data_byte;
   assign rsp_record_done = out_ff.record_done;
   assign rsp_record_mode = out_ff.record_mode;
   assign rsp_name_length = out_ff.name_length;
   assign rsp_body_length = out_ff.body_length;
   assign rsp_hash_ok     = out_ff.hash_ok;
   assign rsp_magic_error = out_ff.magic_error;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives back-to-back archive records, byte by byte, into the deframer and
// checks every result beat against an in-bench parser that tracks the header
// position, the assembled lengths, the Pearson hash and the sticky magic
// error. Both handshakes idle and stall at random, but for one steady phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_byte_class;
   logic [7:0]  rsp_data_byte;
   logic        rsp_record_done;
   logic [23:0] rsp_record_mode;
   logic [15:0] rsp_name_length;
   logic [47:0] rsp_body_length;
   logic        rsp_hash_ok;
   logic        rsp_magic_error;

   archive_record_deframer_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_byte_class  (rsp_byte_class),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_record_done (rsp_record_done),
      .rsp_record_mode (rsp_record_mode),
      .rsp_name_length (rsp_name_length),
      .rsp_body_length (rsp_body_length),
      .rsp_hash_ok     (rsp_hash_ok),
      .rsp_magic_error (rsp_magic_error)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser state as seen by the bench
   logic [3:0]  parse_pos     = ard_pkg::POS_MAGIC;
   logic [48:0] seen_count    = '0;
   logic [23:0] mode_acc      = '0;
   logic [15:0] name_len_acc  = '0;
   logic [47:0] body_len_acc  = '0;
   logic [7:0]  hash_acc      = '0;
   logic        sticky_err    = 1'b0;

   ard_pkg::result_type  predicted_beats[$];
   ard_pkg::result_type  due_beat;
   int          mismatch_count = 0;
   int          bytes_sent = 0;
   bit          source_idles = 1'b1;
   bit          sink_stalls = 1'b1;

   function automatic logic [7:0] pearson_next(input logic [7:0] h, input logic [7:0] b);
      return ard_pkg::PEARSON_ROM[h ^ b];
   endfunction

   // classify one byte and advance the parser state
   function automatic ard_pkg::result_type predict_beat(input logic [7:0] b);
      ard_pkg::result_type  r;
      logic [48:0] total;
      logic        closing;
      r = '0;
      closing = 1'b0;
      r.data_byte = b;
      total = {33'd0, name_len_acc} + {1'b0, body_len_acc};
      if (parse_pos == ard_pkg::POS_MAGIC) begin
         if (b == ard_pkg::MAGIC_BYTE) begin
            r.byte_class = ard_pkg::CLS_MAGIC;
            hash_acc = pearson_next(hash_acc, b);
            parse_pos = parse_pos + 4'd1;
         end else begin
            // hunting for magic, byte not hashed
            r.byte_class = ard_pkg::CLS_ERROR;
            sticky_err = 1'b1;
         end
      end else if (parse_pos <= ard_pkg::POS_MODE_LAST) begin
         r.byte_class = ard_pkg::CLS_MODE;
         mode_acc = {mode_acc[15:0], b};
         hash_acc = pearson_next(hash_acc, b);
         parse_pos = parse_pos + 4'd1;
      end else if (parse_pos <= ard_pkg::POS_NAME_LAST) begin
         r.byte_class = ard_pkg::CLS_NAME_LEN;
         name_len_acc = {name_len_acc[7:0], b};
         hash_acc = pearson_next(hash_acc, b);
         parse_pos = parse_pos + 4'd1;
      end else if (parse_pos < ard_pkg::POS_BODY) begin
         r.byte_class = ard_pkg::CLS_BODY_LEN;
         body_len_acc = {body_len_acc[39:0], b};
         hash_acc = pearson_next(hash_acc, b);
         parse_pos = parse_pos + 4'd1;
      end else if (seen_count < {33'd0, name_len_acc}) begin
         r.byte_class = ard_pkg::CLS_NAME;
         hash_acc = pearson_next(hash_acc, b);
         seen_count = seen_count + 49'd1;
      end else if (seen_count < total) begin
         r.byte_class = ard_pkg::CLS_CONTENT;
         hash_acc = pearson_next(hash_acc, b);
         seen_count = seen_count + 49'd1;
      end else begin
         r.byte_class = ard_pkg::CLS_HASH;
         r.record_done = 1'b1;
         r.hash_ok = (b == hash_acc);
         closing = 1'b1;
      end
      r.record_mode = mode_acc;
      r.name_length = name_len_acc;
      r.body_length = body_len_acc;
      r.magic_error = sticky_err;
      // hash byte reports, then the record state clears
      if (closing) begin
         parse_pos = ard_pkg::POS_MAGIC;
         seen_count = '0;
         mode_acc = '0;
         name_len_acc = '0;
         body_len_acc = '0;
         hash_acc = '0;
      end
      return r;
   endfunction

   // mostly short idles, a few long ones
   function automatic int pick_idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) flag_mismatch(what, want, got);
   endtask

   // result beat checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_beats.size() == 0) begin
            flag_mismatch("unexpected beat, data_byte", 64'd0, 64'(rsp_data_byte));
         end else begin
            due_beat = predicted_beats.pop_front();
            check_field("byte_class", 64'(due_beat.byte_class), 64'(rsp_byte_class));
            check_field("data_byte", 64'(due_beat.data_byte), 64'(rsp_data_byte));
            check_field("record_done", 64'(due_beat.record_done), 64'(rsp_record_done));
            check_field("record_mode", 64'(due_beat.record_mode), 64'(rsp_record_mode));
            check_field("name_length", 64'(due_beat.name_length), 64'(rsp_name_length));
            check_field("body_length", 64'(due_beat.body_length), 64'(rsp_body_length));
            check_field("hash_ok", 64'(due_beat.hash_ok), 64'(rsp_hash_ok));
            check_field("magic_error", 64'(due_beat.magic_error), 64'(rsp_magic_error));
         end
      end
   end

   // result side back-pressure
   always begin
      @(negedge clock);
      if (!reset && sink_stalls && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         if ($urandom_range(0, 99) < 85) repeat ($urandom_range(1, 3)) @(negedge clock);
         else repeat ($urandom_range(10, 40)) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // one input beat, with an optional idle gap ahead of it
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = source_idles ? pick_idle_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (req_stall);
      predicted_beats.push_back(predict_beat(b));
      bytes_sent++;
   endtask

   task automatic release_source();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      release_source();
      while (predicted_beats.size() != 0) @(posedge clock);
   endtask

   // one record; byte_limit cuts it short, negative means whole record
   task automatic send_record(input logic [23:0] mode, input logic [15:0] nlen,
                              input logic [47:0] blen, input bit bad_hash,
                              input int byte_limit);
      logic [95:0] header;
      logic [7:0]  h;
      logic [7:0]  b;
      longint      body_total;
      int          count;
      header = {ard_pkg::MAGIC_BYTE, mode, nlen, blen};
      h = '0;
      count = 0;
      body_total = longint'(nlen) + longint'(blen);
      for (int k = 0; k < 12; k++) begin
         if (count == byte_limit) return;
         b = header[95 - 8 * k -: 8];
         send_byte(b);
         h = pearson_next(h, b);
         count++;
      end
      for (longint i = 0; i < body_total; i++) begin
         if (count == byte_limit) return;
         b = 8'($urandom_range(0, 255));
         send_byte(b);
         h = pearson_next(h, b);
         count++;
      end
      if (count == byte_limit) return;
      send_byte(bad_hash ? (h ^ 8'($urandom_range(1, 255))) : h);
   endtask

   // finish any record left open, keeping header lengths small
   task automatic close_open_record();
      while (parse_pos != ard_pkg::POS_MAGIC)
         send_byte(parse_pos < ard_pkg::POS_BODY ? 8'd0 : 8'($urandom_range(0, 255)));
   endtask

   task automatic test_empty_record();
      send_record(24'h000000, 16'd0, 48'd0, 1'b0, -1);
   endtask

   task automatic test_bad_hash_record();
      send_record(24'hFFFFFF, 16'd1, 48'd1, 1'b1, -1);
   endtask

   task automatic test_magic_hunt();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(~ard_pkg::MAGIC_BYTE);
   endtask

   task automatic test_random_records(input int stop_at);
      int          pick;
      logic [15:0] nlen;
      logic [47:0] blen;
      logic [7:0]  noise;
      while (bytes_sent < stop_at) begin
         close_open_record();
         pick = $urandom_range(0, 99);
         nlen = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 6))
                                              : 16'($urandom_range(7, 24));
         blen = ($urandom_range(0, 99) < 80) ? 48'($urandom_range(0, 10))
                                              : 48'($urandom_range(11, 48));
         if (pick < 78) begin
            send_record(24'($urandom), nlen, blen, 1'b0, -1);
         end else if (pick < 88) begin
            send_record(24'($urandom), nlen, blen, 1'b1, -1);
         end else if (pick < 94) begin
            // truncated record, the next bytes land inside it
            send_record(24'($urandom), nlen, blen, 1'b0,
                        $urandom_range(1, 12 + int'(nlen) + int'(blen)));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               noise = 8'($urandom_range(0, 255));
               if (noise == ard_pkg::MAGIC_BYTE) noise = ~noise;
               send_byte(noise);
            end
         end
      end
      close_open_record();
   endtask

   // all length fields at their maximum; the record never closes
   task automatic test_huge_lengths();
      send_record(24'hFFFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 16);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_empty_record();
      test_bad_hash_record();
      test_magic_hunt();
      test_random_records(1000);

      // sender holds off until the pipe is empty
      wait_for_results();

      source_idles = 1'b0;
      sink_stalls = 1'b0;
      test_random_records(1700);
      source_idles = 1'b1;
      sink_stalls = 1'b1;
      test_random_records(1900);
      test_huge_lengths();

      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && predicted_beats.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: archive_record_deframer_top.f
design/ard_pkg.sv
design/ard_parse.sv
design/archive_record_deframer_top.sv
dv/testbench.sv
